@@ hw/rtl/vmfc_pkg.sv @@
package vmfc_pkg;

    localparam int MAX_TAPS_DEF     = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int RESULT_W         = 32;

    // item command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_PUSH = 1'b1;

    // controls broadcast to every cell of the chain
    typedef struct packed {
        logic push;      // shift the sample line, refresh the working lines
        logic shift_w;   // advance the working sample line toward cell 0
        logic shift_g;   // advance the working tap line toward cell 0
    } t_cell_ctrl;

endpackage

@@ hw/rtl/vmfc_if.sv @@
interface vmfc_item_if #(
    parameter int SAMPLE_WIDTH = vmfc_pkg::SAMPLE_WIDTH_DEF,
    parameter int IDX_W        = $clog2(vmfc_pkg::MAX_TAPS_DEF)
);
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [IDX_W-1:0]               tap_index;
    logic signed [SAMPLE_WIDTH-1:0] coefficient;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           first_sample;
    logic                           last_sample;

    modport source (
        output valid, command, tap_index, coefficient, sample, first_sample, last_sample,
        input  ready
    );
    modport sink (
        input  valid, command, tap_index, coefficient, sample, first_sample, last_sample,
        output ready
    );
endinterface

interface vmfc_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [vmfc_pkg::RESULT_W-1:0] result;
    logic                                 saturated;
    logic                                 last_result;

    modport source (
        output valid, result, saturated, last_result,
        input  ready
    );
    modport sink (
        input  valid, result, saturated, last_result,
        output ready
    );
endinterface

interface vmfc_cfg_if #(
    parameter int CNT_W = $clog2(vmfc_pkg::MAX_TAPS_DEF + 1)
);
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] tap_count;

    modport source (
        output valid, tap_count,
        input  ready
    );
    modport sink (
        input  valid, tap_count,
        output ready
    );
endinterface

@@ hw/rtl/valid_mode_fir_correlator.sv @@
// Channel   Dir  Modport  Request carries
// i_item    in   sink     command, tap_index, coefficient, sample, first/last flags
// o_result  out  source   result, saturated, last_result
// i_cfg     in   sink     tap_count
//
// A load request and a push that gives no result leave the sequencer in S_IDLE, ready.
// A push that gives a result runs S_ALIGN to align the working sample line (skipped
// when T equals MAX_TAPS), S_MAC to feed the single multiply-accumulate at cell 0,
// S_DRAIN to add the last product and S_DONE to hand the sum to the output register.
// Reset (i_rst_n, synchronous) clears the control and fill count and sets tap count to 1.
// A held result keeps the next finished sum waiting, and i_item and i_cfg wait with it.
module valid_mode_fir_correlator #(
    parameter int MAX_TAPS     = vmfc_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_WIDTH = vmfc_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    vmfc_item_if.sink      i_item,
    vmfc_result_if.source  o_result,
    vmfc_cfg_if.sink       i_cfg
);

    localparam int IDX_W  = $clog2(MAX_TAPS);
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int FRAC   = SAMPLE_WIDTH - 1;
    localparam int PROD_W = 2 * SAMPLE_WIDTH;
    localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
    localparam int SH_W   = ACC_W - FRAC;
    localparam int EXT_W  = (SH_W > vmfc_pkg::RESULT_W + 1) ? SH_W : vmfc_pkg::RESULT_W + 1;
    localparam int RW     = vmfc_pkg::RESULT_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ALIGN = 5'b00010,
        S_MAC   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                     r_state, n_state;
    logic [CNT_W-1:0]           r_tap_count;
    logic [CNT_W-1:0]           r_fill, n_fill;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic                       r_last;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_out_valid;
    logic signed [RW-1:0]       r_out_result;
    logic                       r_out_sat;
    logic                       r_out_last;

    logic                       item_fire;
    logic                       push_fire;
    logic                       load_fire;
    logic [CNT_W-1:0]           eff_taps;
    logic                       out_free;
    vmfc_pkg::t_cell_ctrl       cell_ctrl;

    logic signed [SAMPLE_WIDTH-1:0] sample_q [MAX_TAPS];
    logic signed [SAMPLE_WIDTH-1:0] work_q   [MAX_TAPS];
    logic signed [SAMPLE_WIDTH-1:0] coef_q   [MAX_TAPS];

    logic signed [SH_W-1:0]     acc_sh;
    logic signed [EXT_W-1:0]    acc_ext;
    logic signed [EXT_W-1:0]    lim_hi;
    logic signed [EXT_W-1:0]    lim_lo;
    logic signed [RW-1:0]       sum_q;
    logic                       sum_sat;

    assign i_item.ready = (r_state == S_IDLE);
    // hold tap count writes while a sum is in progress
    assign i_cfg.ready  = (r_state == S_IDLE);
    assign item_fire    = i_item.valid && i_item.ready;
    assign push_fire    = item_fire && (i_item.command == vmfc_pkg::CMD_PUSH);
    assign load_fire    = item_fire && (i_item.command == vmfc_pkg::CMD_LOAD);
    assign out_free     = !r_out_valid || o_result.ready;

    always_comb begin
        if (r_tap_count == '0) begin
            eff_taps = CNT_W'(1);
        end else if (r_tap_count > CNT_W'(MAX_TAPS)) begin
            eff_taps = CNT_W'(MAX_TAPS);
        end else begin
            eff_taps = r_tap_count;
        end
    end

    always_comb begin
        n_fill = i_item.first_sample ? '0 : r_fill;
        if (n_fill < CNT_W'(MAX_TAPS)) begin
            n_fill = n_fill + CNT_W'(1);
        end
    end

    // ---------------- cell chain ----------------
    always_comb begin
        cell_ctrl.push    = push_fire;
        cell_ctrl.shift_w = (r_state == S_ALIGN) || (r_state == S_MAC);
        cell_ctrl.shift_g = (r_state == S_MAC);
    end

    for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
        logic signed [SAMPLE_WIDTH-1:0] sample_next;
        logic signed [SAMPLE_WIDTH-1:0] work_next;
        logic signed [SAMPLE_WIDTH-1:0] coef_next;
        logic                           tap_we;

        if (j == MAX_TAPS - 1) begin : g_top
            // new sample enters at the far end; zeros fill behind the working lines
            assign sample_next = i_item.sample;
            assign work_next   = '0;
            assign coef_next   = '0;
        end else begin : g_mid
            assign sample_next = sample_q[j+1];
            assign work_next   = work_q[j+1];
            assign coef_next   = coef_q[j+1];
        end

        assign tap_we = load_fire && (i_item.tap_index == IDX_W'(j));

        vmfc_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (cell_ctrl),
            .i_tap_we      (tap_we),
            .i_tap_data    (i_item.coefficient),
            .i_sample_next (sample_next),
            .i_work_next   (work_next),
            .i_coef_next   (coef_next),
            .o_sample      (sample_q[j]),
            .o_work        (work_q[j]),
            .o_coef        (coef_q[j])
        );
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (push_fire && (n_fill >= eff_taps)) begin
                    if (eff_taps == CNT_W'(MAX_TAPS)) begin
                        n_state = S_MAC;
                        n_cnt   = eff_taps;
                    end else begin
                        n_state = S_ALIGN;
                        n_cnt   = CNT_W'(MAX_TAPS) - eff_taps;
                    end
                end
            end
            S_ALIGN: begin
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_MAC;
                    n_cnt   = eff_taps;
                end
            end
            S_MAC: begin
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_fill      <= '0;
            r_tap_count <= CNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (push_fire) begin
                r_fill <= n_fill;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_tap_count <= i_cfg.tap_count;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // multiply at cell 0, accumulate in the next cycle
    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_last <= i_item.last_sample;
            r_prod <= '0;
            r_acc  <= '0;
        end else begin
            if (r_state == S_MAC) begin
                r_prod <= work_q[0] * coef_q[0];
            end
            if (r_state == S_MAC || r_state == S_DRAIN) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    // floor by arithmetic shift, then clip to the result range
    always_comb begin
        acc_sh  = SH_W'(r_acc >>> FRAC);
        acc_ext = EXT_W'(acc_sh);
        lim_hi  = $signed({{(EXT_W-RW+1){1'b0}}, {(RW-1){1'b1}}});
        lim_lo  = $signed({{(EXT_W-RW+1){1'b1}}, {(RW-1){1'b0}}});
        sum_sat = 1'b0;
        sum_q   = acc_ext[RW-1:0];
        if (acc_ext > lim_hi) begin
            sum_q   = lim_hi[RW-1:0];
            sum_sat = 1'b1;
        end else if (acc_ext < lim_lo) begin
            sum_q   = lim_lo[RW-1:0];
            sum_sat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_result <= sum_q;
            r_out_sat    <= sum_sat;
            r_out_last   <= r_last;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.result      = r_out_result;
    assign o_result.saturated   = r_out_sat;
    assign o_result.last_result = r_out_last;

    // ---------------- assertions ----------------
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(MAX_TAPS))
        else $error("fill count beyond tap capacity");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !o_result.ready) |=> (r_state == S_DONE))
        else $error("finished sum left while output register was full");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result presented without a finished sum");

    a_mac_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC || r_state == S_ALIGN) |-> (r_cnt != '0))
        else $error("sequencer step count ran out");

endmodule

@@ hw/rtl/vmfc_cell.sv @@
module vmfc_cell #(
    parameter int SAMPLE_WIDTH = vmfc_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  vmfc_pkg::t_cell_ctrl           i_ctrl,
    input  logic                           i_tap_we,
    input  logic signed [SAMPLE_WIDTH-1:0] i_tap_data,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_next,
    input  logic signed [SAMPLE_WIDTH-1:0] i_work_next,
    input  logic signed [SAMPLE_WIDTH-1:0] i_coef_next,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample,
    output logic signed [SAMPLE_WIDTH-1:0] o_work,
    output logic signed [SAMPLE_WIDTH-1:0] o_coef
);

    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic signed [SAMPLE_WIDTH-1:0] r_tap;
    logic signed [SAMPLE_WIDTH-1:0] r_work;
    logic signed [SAMPLE_WIDTH-1:0] r_coef;

    always_ff @(posedge i_clk) begin
        if (i_tap_we) begin
            r_tap <= i_tap_data;
        end
        if (i_ctrl.push) begin
            r_sample <= i_sample_next;
            // working copy takes the post-shift sample and the current tap
            r_work   <= i_sample_next;
            r_coef   <= r_tap;
        end else begin
            if (i_ctrl.shift_w) begin
                r_work <= i_work_next;
            end
            if (i_ctrl.shift_g) begin
                r_coef <= i_coef_next;
            end
        end
    end

    assign o_sample = r_sample;
    assign o_work   = r_work;
    assign o_coef   = r_coef;

endmodule

@@ sim/valid_mode_fir_correlator_test.sv @@
`timescale 1ns / 1ps

typedef struct packed {
    logic               command;
    logic [5:0]         tap_index;
    logic signed [15:0] coefficient;
    logic signed [15:0] sample;
    logic               first_sample;
    logic               last_sample;
} t_corr_req;

typedef struct packed {
    logic signed [31:0] value;
    logic               saturated;
    logic               last_result;
} t_corr_out;

class corr_scoreboard;
    localparam int NTAPS = vmfc_pkg::MAX_TAPS_DEF;
    localparam int FRAC  = vmfc_pkg::SAMPLE_WIDTH_DEF - 1;

    logic signed [15:0] taps [NTAPS];
    logic signed [15:0] history [NTAPS];
    int unsigned        fill;
    int unsigned        tap_count;
    t_corr_out          pending_sums [$];
    int                 errors;

    function new();
        fill      = 0;
        tap_count = 1;
        errors    = 0;
        foreach (taps[i]) taps[i] = '0;
        foreach (history[i]) history[i] = '0;
    endfunction

    function void set_tap_count(logic [6:0] v);
        tap_count = 32'(v);
    endfunction

    function int pending();
        return pending_sums.size();
    endfunction

    task report(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Update the tap table or the sample line; queue a sum once the kernel is covered.
    function void note_request(t_corr_req r);
        longint      acc;
        int unsigned t;
        t_corr_out   e;
        if (r.command == vmfc_pkg::CMD_LOAD) begin
            taps[r.tap_index] = r.coefficient;
            return;
        end
        if (r.first_sample) fill = 0;
        for (int k = NTAPS - 1; k > 0; k--) history[k] = history[k - 1];
        history[0] = r.sample;
        if (fill < NTAPS) fill++;
        t = (tap_count == 0) ? 1 : (tap_count > NTAPS) ? NTAPS : tap_count;
        if (fill < t) return;
        acc = 0;
        // newest sample meets the last tap
        for (int k = 0; k < t; k++)
            acc += longint'(taps[k]) * longint'(history[t - 1 - k]);
        acc = acc >>> FRAC;
        e.saturated = 1'b0;
        if (acc > 64'sd2147483647) begin
            acc = 64'sd2147483647;
            e.saturated = 1'b1;
        end else if (acc < -64'sd2147483648) begin
            acc = -64'sd2147483648;
            e.saturated = 1'b1;
        end
        e.value       = acc[31:0];
        e.last_result = r.last_sample;
        pending_sums.push_back(e);
    endfunction

    task check_result(input t_corr_out got);
        t_corr_out e;
        if (pending_sums.size() == 0) begin
            report($sformatf("result %0d with no sum pending", got.value));
            return;
        end
        e = pending_sums.pop_front();
        if (got.value !== e.value)
            report($sformatf("result %0d, want %0d", got.value, e.value));
        if (got.saturated !== e.saturated)
            report($sformatf("saturated %b, want %b", got.saturated, e.saturated));
        if (got.last_result !== e.last_result)
            report($sformatf("last_result %b, want %b", got.last_result, e.last_result));
    endtask
endclass

module valid_mode_fir_correlator_test;
    localparam int MAX_TAPS     = vmfc_pkg::MAX_TAPS_DEF;
    localparam int DRAIN_CYCLES = MAX_TAPS + 8;
    localparam int NUM_PHASES   = 14;
    localparam int REQ_W        = $bits(t_corr_req);

    logic i_clk = 1'b0;
    logic i_rst_n;

    vmfc_item_if   item_ch ();
    vmfc_result_if res_ch ();
    vmfc_cfg_if    cfg_ch ();

    corr_scoreboard sb = new();
    bit             idle_on = 1'b1;
    int             long_hold_cycles = 0;
    logic [6:0]     phase_taps [NUM_PHASES] = '{7'd1, 7'd64, 7'd127, 7'd0, 7'd2, 7'd7,
                                                7'd33, 7'd65, 7'd3, 7'd16, 7'd5, 7'd48,
                                                7'd12, 7'd4};

    valid_mode_fir_correlator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        item_ch.valid        <= 1'b0;
        item_ch.command      <= vmfc_pkg::CMD_LOAD;
        item_ch.tap_index    <= '0;
        item_ch.coefficient  <= '0;
        item_ch.sample       <= '0;
        item_ch.first_sample <= 1'b0;
        item_ch.last_sample  <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.tap_count     <= 7'd1;
    end

    initial begin
        #3_000_000;
        $display("** valid_mode_fir_correlator: FAILED **");
        $finish;
    end

    // Result side: random back-pressure bursts, plus one long hold on demand.
    initial begin : result_sink
        int n;
        res_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (long_hold_cycles > 0) begin
                n = long_hold_cycles;
                long_hold_cycles = 0;
                res_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
                res_ch.ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 4);
                res_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_corr_out got;
        t_corr_req req;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                got.value       = res_ch.result;
                got.saturated   = res_ch.saturated;
                got.last_result = res_ch.last_result;
                sb.check_result(got);
            end
            if (item_ch.valid && item_ch.ready) begin
                req.command      = item_ch.command;
                req.tap_index    = item_ch.tap_index;
                req.coefficient  = item_ch.coefficient;
                req.sample       = item_ch.sample;
                req.first_sample = item_ch.first_sample;
                req.last_sample  = item_ch.last_sample;
                sb.note_request(req);
            end
        end
    end

    function automatic logic signed [15:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input t_corr_req r);
        int n;
        item_ch.valid        <= 1'b1;
        item_ch.command      <= r.command;
        item_ch.tap_index    <= r.tap_index;
        item_ch.coefficient  <= r.coefficient;
        item_ch.sample       <= r.sample;
        item_ch.first_sample <= r.first_sample;
        item_ch.last_sample  <= r.last_sample;
        do @(posedge i_clk); while (!item_ch.ready);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 4);
            item_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Unused fields of each request carry random values.
    task automatic load_tap(input logic [5:0] idx, input logic signed [15:0] coef);
        t_corr_req r;
        r              = REQ_W'({$urandom, $urandom});
        r.command      = vmfc_pkg::CMD_LOAD;
        r.tap_index    = idx;
        r.coefficient  = coef;
        r.first_sample = 1'($urandom);
        r.last_sample  = 1'($urandom);
        send_item(r);
    endtask

    task automatic push_sample(input logic signed [15:0] s, input logic first, input logic last);
        t_corr_req r;
        r              = REQ_W'({$urandom, $urandom});
        r.command      = vmfc_pkg::CMD_PUSH;
        r.sample       = s;
        r.first_sample = first;
        r.last_sample  = last;
        send_item(r);
    endtask

    task automatic wait_idle();
        int guard;
        item_ch.valid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tap_count(input logic [6:0] v);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.tap_count <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.set_tap_count(v);
    endtask

    task automatic random_phase(input logic [6:0] setting, input int n_items, input bit pressure);
        int t, len, i, sent;
        bit first, last;
        wait_idle();
        write_tap_count(setting);
        t = (setting == 0) ? 1 : (setting > MAX_TAPS) ? MAX_TAPS : setting;
        if (pressure) long_hold_cycles = 400;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 9))
                0, 1:    len = $urandom_range(1, t);
                2:       len = $urandom_range(t, t + 80);
                default: len = $urandom_range(t, t + 12);
            endcase
            for (i = 0; i < len; i++) begin
                if ($urandom_range(0, 15) == 0) begin
                    load_tap(6'($urandom_range(0, MAX_TAPS - 1)), rand_word());
                    sent++;
                end
                // mostly well-formed signals, with stray start and end flags
                first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
                last  = (i == len - 1) ? ($urandom_range(0, 9) != 0)
                                       : ($urandom_range(0, 49) == 0);
                push_sample(rand_word(), first, last);
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        int p;
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill the whole tap table so no unwritten tap is ever read
        for (p = 0; p < MAX_TAPS; p++) begin
            if (p == 0 || p == 2)
                load_tap(6'(p), 16'sh8000);
            else if (p == 1 || p == MAX_TAPS - 1)
                load_tap(6'(p), 16'sh7FFF);
            else
                load_tap(6'(p), rand_word());
        end

        // single tap from reset
        push_sample(16'sh7FFF, 1'b1, 1'b0);
        push_sample(16'sh8000, 1'b0, 1'b0);
        push_sample(16'sh0000, 1'b0, 1'b1);
        wait_idle();
        write_tap_count(7'd0);
        push_sample(16'sh8000, 1'b1, 1'b1);
        push_sample(16'shFFFF, 1'b0, 1'b0);
        wait_idle();
        write_tap_count(7'd3);
        push_sample(16'sh7FFF, 1'b1, 1'b0);
        push_sample(16'sh8000, 1'b0, 1'b1);
        // no start flag: keep filling from the previous signal
        push_sample(16'sh7FFF, 1'b0, 1'b0);
        load_tap(6'd1, 16'sh8000);
        push_sample(16'sh8000, 1'b0, 1'b0);
        push_sample(16'sh1234, 1'b1, 1'b0);
        push_sample(16'sh8000, 1'b0, 1'b0);
        push_sample(16'sh7FFF, 1'b0, 1'b1);
        // raise the tap count against a partly filled signal
        wait_idle();
        write_tap_count(7'd5);
        push_sample(16'sh7FFF, 1'b0, 1'b0);
        push_sample(16'sh8000, 1'b0, 1'b1);

        for (p = 0; p < NUM_PHASES; p++) begin
            if (p == NUM_PHASES - 1) idle_on = 1'b0;
            random_phase(phase_taps[p], 100, p == 8);
        end

        wait_idle();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d sums never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("** valid_mode_fir_correlator: PASSED **");
        else
            $display("** valid_mode_fir_correlator: FAILED **");
        $finish;
    end
endmodule
